// ----- hdl/brl_pkg.sv -----
// ----------------------------------------------------------------------------
// brl_pkg: shared types and constants of the line rasterizer
// Field widths, register codes, reset values and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package brl_pkg;

	// Fixed field widths of the request and pixel beats and the clip registers
	localparam int COORD_W = 6;
	localparam int COLOR_W = 3;
	localparam int CLIP_W  = 7;

	// Configuration port
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 1'b1;

	localparam logic [CLIP_W-1:0] CLIP_WIDTH_RST  = 7'd64;
	localparam logic [CLIP_W-1:0] CLIP_HEIGHT_RST = 7'd25;

	// Pen colors
	localparam logic [COLOR_W-1:0] COLOR_DEFAULT = 3'd4;

	// Controller to datapath
	typedef struct packed {
		logic load;  // capture a request and set up deltas
		logic step;  // advance to the next pixel of the line
	} brl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic at_end;  // current pixel equals the end point
	} brl_status_t;

endpackage

// ----- hdl/brl_if.sv -----
// ----------------------------------------------------------------------------
// brl_req_if / brl_pix_if: valid-ready channels of the line rasterizer
// One beat of brl_req_if carries a line request; one beat of brl_pix_if
// carries one pixel of the line.
// ----------------------------------------------------------------------------
interface brl_req_if import brl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;
	logic [COLOR_W-1:0] pen_color;

	modport source (output valid, start_x, start_y, end_x, end_y, pen_color, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, pen_color, output ready);
endinterface

interface brl_pix_if import brl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [COLOR_W-1:0] pixel_color;
	logic               in_window;
	logic               last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, in_window, last_pixel,
		input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_color, in_window, last_pixel,
		output ready);
endinterface

// ----- hdl/brl_ctrl.sv -----
// ----------------------------------------------------------------------------
// brl_ctrl: sequencing of the line rasterizer
// Takes a request when idle, then walks the line one pixel per pixel beat
// and returns to idle once the end pixel has been taken.
// ----------------------------------------------------------------------------
module brl_ctrl import brl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output brl_cmd_t    cmd,
	input  brl_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_fire;
	logic   out_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_RUN);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	// Drive datapath commands
	always_comb begin
		cmd.load = in_fire;
		cmd.step = out_fire && !status.at_end;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (out_fire && status.at_end) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/brl_dp.sv -----
// ----------------------------------------------------------------------------
// brl_dp: datapath of the line rasterizer
// Holds the clip window, sets up deltas and the error term on load, and
// makes one Bresenham step per step command. The current point registers
// drive the pixel beat directly.
// ----------------------------------------------------------------------------
module brl_dp import brl_pkg::*; #(
	parameter int COORD_BITS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CLIP_W-1:0]    cfg_data,
	input  brl_cmd_t             cmd,
	output brl_status_t          status,
	brl_req_if.sink              req,
	brl_pix_if.source            pix
);

	// Error term needs room for twice either delta plus sign
	localparam int ERR_W = COORD_BITS + 3;
	localparam int E2_W  = ERR_W + 1;

	logic [CLIP_W-1:0] clip_w_q;
	logic [CLIP_W-1:0] clip_h_q;

	logic [COORD_BITS-1:0] x0, y0, x1, y1;
	logic [COORD_BITS-1:0] dx_w, dy_w;
	logic [COLOR_W-1:0]    color_w;

	logic [COORD_BITS-1:0] x_q, y_q, x1_q, y1_q;
	logic [COORD_BITS-1:0] dx_q, dy_q;
	logic                  sx_neg_q, sy_neg_q;
	logic signed [ERR_W-1:0] err_q;
	logic [COLOR_W-1:0]    color_q;

	logic signed [E2_W-1:0]  e2;
	logic signed [E2_W-1:0]  dx_e, dy_e;
	logic                    step_x, step_y;
	logic signed [ERR_W-1:0] err_d;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_w_q <= CLIP_WIDTH_RST;
			clip_h_q <= CLIP_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLIP_WIDTH:  clip_w_q <= cfg_data;
				CFG_CLIP_HEIGHT: clip_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Setup: mask coordinates, absolute deltas, clamp color
	assign x0 = req.start_x[COORD_BITS-1:0];
	assign y0 = req.start_y[COORD_BITS-1:0];
	assign x1 = req.end_x[COORD_BITS-1:0];
	assign y1 = req.end_y[COORD_BITS-1:0];
	assign dx_w = (x1 > x0) ? (x1 - x0) : (x0 - x1);
	assign dy_w = (y1 > y0) ? (y1 - y0) : (y0 - y1);
	assign color_w = (req.pen_color > COLOR_DEFAULT) ? COLOR_DEFAULT : req.pen_color;

	// Step decision on the doubled error
	assign e2     = {err_q, 1'b0};
	assign dx_e   = $signed(E2_W'(dx_q));
	assign dy_e   = $signed(E2_W'(dy_q));
	assign step_x = e2 > -dy_e;
	assign step_y = e2 < dx_e;
	assign err_d  = err_q - (step_x ? $signed(ERR_W'(dy_q)) : '0)
		+ (step_y ? $signed(ERR_W'(dx_q)) : '0);

	// Line registers: load on accept, advance on step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= x0;
			y_q      <= y0;
			x1_q     <= x1;
			y1_q     <= y1;
			dx_q     <= dx_w;
			dy_q     <= dy_w;
			sx_neg_q <= !(x0 < x1);
			sy_neg_q <= !(y0 < y1);
			err_q    <= $signed(ERR_W'(dx_w)) - $signed(ERR_W'(dy_w));
			color_q  <= color_w;
		end else if (cmd.step) begin
			err_q <= err_d;
			if (step_x) x_q <= sx_neg_q ? x_q - 1'b1 : x_q + 1'b1;
			if (step_y) y_q <= sy_neg_q ? y_q - 1'b1 : y_q + 1'b1;
		end
	end

	assign status.at_end = (x_q == x1_q) && (y_q == y1_q);

	// Pixel beat payload
	assign pix.pixel_x     = COORD_W'(x_q);
	assign pix.pixel_y     = COORD_W'(y_q);
	assign pix.pixel_color = color_q;
	assign pix.in_window   = (CLIP_W'(x_q) < clip_w_q) && (CLIP_W'(y_q) < clip_h_q);
	assign pix.last_pixel  = status.at_end;

endmodule

// ----- hdl/bresenham_line_raster.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_raster: Bresenham line rasterizer
// Takes one line request (start point, end point, pen color) on req and
// emits every pixel of the line, start to end, on pix, one beat per pixel,
// the end pixel flagged last_pixel. When a request is taken, deltas and the
// error term are set up; the line's max(|dx|,|dy|)+1 pixels then leave at
// one per cycle while pix is ready, and req is ready again the cycle after
// the last pixel is taken. in_window compares each pixel against clip_width
// (register 0) and clip_height (register 1), written via cfg_we; write them
// only while the block is idle. Pen colors above 4 come out as 4.
// ----------------------------------------------------------------------------
module bresenham_line_raster import brl_pkg::*; #(
	parameter int COORD_BITS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CLIP_W-1:0]    cfg_data,
	brl_req_if.sink              req,
	brl_pix_if.source            pix
);

	brl_cmd_t    cmd;
	brl_status_t status;

	// Sequencer
	brl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (pix.valid),
		.out_ready (pix.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Line stepping and clip test
	brl_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.req       (req),
		.pix       (pix)
	);

	// One request in flight at a time
	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid |-> !req.ready)
		else $error("request taken while a line is still being drawn");

	// First pixel follows an accepted request
	a_first_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> pix.valid)
		else $error("no pixel after an accepted request");

	// Taking the end pixel closes the line
	a_line_close: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready && pix.last_pixel) |=> (req.ready && !pix.valid))
		else $error("line did not close after its end pixel");

	// Each non-final pixel beat moves the point
	a_point_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready && !pix.last_pixel) |=>
		(pix.valid && ($past(pix.pixel_x) != pix.pixel_x
		|| $past(pix.pixel_y) != pix.pixel_y)))
		else $error("pixel beat taken without a step");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for bresenham_line_raster
// Drives line requests on the req channel, traces every line in a local
// Bresenham predictor and checks each pixel beat on the pix channel, field by
// field, against the oldest traced pixel. Runs directed corner lines first,
// then random lines under several clip windows, with random idling on both
// channels in all but the last window and one long hold-off on the pixel side.
// ----------------------------------------------------------------------------
module tb;
	import brl_pkg::*;

	localparam int LINE_MAX    = 64;    // pixels in the longest line
	localparam int HOLD_OFF    = 300;   // long pixel-side hold-off, cycles
	localparam int STALL_LIMIT = 4000;  // cycles with no beat before giving up
	localparam int TAIL_CYCLES = 70;    // settle time after the last pixel
	localparam int PHASE_LINES = 76;    // random lines per clip setting
	localparam int NUM_PHASES  = 6;

	typedef struct packed {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [COLOR_W-1:0] color;
		logic               in_win;
		logic               last;
	} pixel_t;

	// Traces requested lines into pixels and checks the pixel beats
	class line_scoreboard;
		pixel_t due_pixels[$];
		int     clip_w = int'(CLIP_WIDTH_RST);
		int     clip_h = int'(CLIP_HEIGHT_RST);
		int     errors = 0;

		function void set_clip(logic [CFG_IDX_W-1:0] idx, logic [CLIP_W-1:0] val);
			if (idx == CFG_CLIP_WIDTH)
				clip_w = int'(val);
			else
				clip_h = int'(val);
		endfunction

		function void flag(string what, pixel_t want, pixel_t got);
			errors++;
			if (errors <= 10)
				$display("%s: expected x=%0d y=%0d c=%0d win=%0b last=%0b, got x=%0d y=%0d c=%0d win=%0b last=%0b",
					what, want.px, want.py, want.color, want.in_win, want.last,
					got.px, got.py, got.color, got.in_win, got.last);
		endfunction

		// Walk the line start to end, one pixel per step
		function void note_request(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
			logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1, logic [COLOR_W-1:0] pen);
			int     xs, ys, xe, ye, dx, dy, sx, sy, err, e2;
			pixel_t p;
			xs = int'(x0);
			ys = int'(y0);
			xe = int'(x1);
			ye = int'(y1);
			dx = (xe > xs) ? xe - xs : xs - xe;
			dy = (ye > ys) ? ye - ys : ys - ye;
			sx = (xs < xe) ? 1 : -1;
			sy = (ys < ye) ? 1 : -1;
			err = dx - dy;
			p.color = (pen > COLOR_DEFAULT) ? COLOR_DEFAULT : pen;
			for (int n = 0; n < LINE_MAX; n++) begin
				p.px     = xs[COORD_W-1:0];
				p.py     = ys[COORD_W-1:0];
				p.in_win = (xs < clip_w) && (ys < clip_h);
				p.last   = (xs == xe) && (ys == ye);
				due_pixels.insert(due_pixels.size(), p);
				if (p.last)
					break;
				e2 = 2 * err;
				if (e2 > -dy) begin
					err -= dy;
					xs += sx;
				end
				if (e2 < dx) begin
					err += dx;
					ys += sy;
				end
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (due_pixels.size() == 0) begin
				flag("unexpected pixel", '0, got);
				return;
			end
			want = due_pixels.pop_front();
			if (got.px !== want.px || got.py !== want.py || got.color !== want.color ||
				got.in_win !== want.in_win || got.last !== want.last)
				flag("pixel mismatch", want, got);
		endfunction

		function int outstanding();
			return due_pixels.size();
		endfunction

		// Count every traced pixel that never came out
		function void close_out();
			while (due_pixels.size() != 0)
				flag("missing pixel", due_pixels.pop_front(), '0);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CLIP_W-1:0]    cfg_data;

	brl_req_if req_ch();
	brl_pix_if pix_ch();

	line_scoreboard sb = new();

	bit sender_idle_on = 1'b0;
	bit sink_stall_on  = 1'b0;
	bit long_hold_req  = 1'b0;
	int quiet_cycles   = 0;

	bresenham_line_raster #(.COORD_BITS(6)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.pix       (pix_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Record request beats, check pixel beats, watch for a hang
	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			sb.note_request(req_ch.start_x, req_ch.start_y, req_ch.end_x, req_ch.end_y,
				req_ch.pen_color);
		if (pix_ch.valid && pix_ch.ready)
			sb.check_pixel({pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_color,
				pix_ch.in_window, pix_ch.last_pixel});
		if ((req_ch.valid && req_ch.ready) || (pix_ch.valid && pix_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Drive pix ready: random stall bursts, one long hold-off on request
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		pix_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cnt > 0) begin
				hold_cnt--;
				pix_ch.ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_cnt = HOLD_OFF - 1;
				pix_ch.ready <= 1'b0;
			end else if (sink_stall_on && $urandom_range(0, 7) == 0) begin
				hold_cnt = $urandom_range(0, 9);
				pix_ch.ready <= 1'b0;
			end else begin
				pix_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one request and hold it until the beat is taken
	task automatic send_line(int x0, int y0, int x1, int y1, int pen);
		req_ch.valid     <= 1'b1;
		req_ch.start_x   <= x0[COORD_W-1:0];
		req_ch.start_y   <= y0[COORD_W-1:0];
		req_ch.end_x     <= x1[COORD_W-1:0];
		req_ch.end_y     <= y1[COORD_W-1:0];
		req_ch.pen_color <= pen[COLOR_W-1:0];
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (sender_idle_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// Mostly short lines, some full-range ones, a few single points
	task automatic send_random_line();
		int kind, x0, y0, x1, y1;
		kind = $urandom_range(0, 9);
		x0 = $urandom_range(0, 63);
		y0 = $urandom_range(0, 63);
		if (kind == 0) begin
			x1 = x0;
			y1 = y0;
		end else if (kind <= 6) begin
			x1 = x0 + $urandom_range(0, 14) - 7;
			y1 = y0 + $urandom_range(0, 14) - 7;
			x1 = (x1 < 0) ? 0 : (x1 > 63) ? 63 : x1;
			y1 = (y1 < 0) ? 0 : (y1 > 63) ? 63 : y1;
		end else begin
			x1 = $urandom_range(0, 63);
			y1 = $urandom_range(0, 63);
		end
		send_line(x0, y0, x1, y1, $urandom_range(0, 7));
	endtask

	// Drop valid and wait until every traced pixel has come out
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// Write both clip registers; the block must be idle
	task automatic set_window(int w, int h);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CLIP_WIDTH;
		cfg_data  <= w[CLIP_W-1:0];
		@(posedge clk);
		sb.set_clip(CFG_CLIP_WIDTH, w[CLIP_W-1:0]);
		cfg_index <= CFG_CLIP_HEIGHT;
		cfg_data  <= h[CLIP_W-1:0];
		@(posedge clk);
		sb.set_clip(CFG_CLIP_HEIGHT, h[CLIP_W-1:0]);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int win_w[NUM_PHASES];
		int win_h[NUM_PHASES];
		win_w = '{64, 1, 0, 127, 33, 0};
		win_h = '{64, 1, 0, 127, 47, 0};
		win_w[NUM_PHASES-1] = $urandom_range(1, 64);
		win_h[NUM_PHASES-1] = $urandom_range(1, 64);

		arst_n           = 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_CLIP_WIDTH;
		cfg_data         <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.start_x   <= '0;
		req_ch.start_y   <= '0;
		req_ch.end_x     <= '0;
		req_ch.end_y     <= '0;
		req_ch.pen_color <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines under the reset window: points, axes, diagonals, octants
		send_line(0, 0, 0, 0, 0);
		send_line(63, 63, 63, 63, 1);
		send_line(0, 0, 63, 63, 2);
		send_line(63, 63, 0, 0, 3);
		send_line(0, 24, 63, 24, 4);
		send_line(63, 25, 0, 25, 5);
		send_line(63, 0, 63, 63, 6);
		send_line(0, 63, 0, 0, 7);
		send_line(0, 63, 63, 0, 0);
		send_line(63, 0, 0, 63, 1);
		send_line(5, 10, 30, 17, 2);
		send_line(30, 17, 5, 10, 3);
		send_line(10, 5, 17, 30, 4);
		send_line(17, 30, 10, 5, 5);
		send_line(40, 2, 12, 9, 6);
		send_line(2, 40, 9, 12, 7);
		send_line(21, 42, 42, 21, 0);
		send_line(62, 1, 63, 0, 4);
		send_line(31, 32, 32, 31, 7);
		send_line(0, 0, 1, 63, 2);
		drain();

		// Random lines, one clip setting per phase
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_window(win_w[ph], win_h[ph]);
			sender_idle_on = (ph != NUM_PHASES - 1);
			sink_stall_on  = (ph != NUM_PHASES - 1);
			if (ph == 0) begin
				// hold pixels off while the sender offers requests with no idle gaps
				sender_idle_on = 1'b0;
				long_hold_req  = 1'b1;
			end
			for (int i = 0; i < PHASE_LINES; i++) begin
				if (ph == 0 && i == 20)
					sender_idle_on = 1'b1;
				send_random_line();
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/brl_pkg.sv
hdl/brl_if.sv
hdl/brl_ctrl.sv
hdl/brl_dp.sv
hdl/bresenham_line_raster.sv
tb/tb.sv
